// ----- rtl/ltdc_pkg.sv -----
// Shared types, widths, codes and a helper function of the line trace drive controller.
// No dependencies; every other file imports this package.
package ltdc_pkg;

  // Field widths
  localparam int SENSOR_BITS = 10;
  localparam int OP_W        = 2;
  localparam int BATT_W      = 14;
  localparam int SPEED_W     = 8;
  localparam int TURN_MAG_W  = 7;
  localparam int GAIN_W      = 24;
  localparam int FWD_W       = 10;
  localparam int TURN_W      = 8;
  localparam int TONE_W      = 2;
  localparam int SUM_W       = 32;

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // PID datapath widths
  localparam int E_W    = SENSOR_BITS + 1;
  localparam int DE_W   = E_W + 1;
  localparam int PP_W   = GAIN_W + 1 + E_W;
  localparam int PI_W   = GAIN_W + 1 + SUM_W;
  localparam int PD_W   = GAIN_W + 1 + DE_W;
  localparam int ACC_W  = PI_W + 2;
  localparam int FRAC_W = 16;

  // Comparison widths
  localparam int BATT_X_W  = BATT_W + 1;
  localparam int LIGHT_X_W = SENSOR_BITS + 1;

  // Constants
  localparam int ONOFF_MARGIN = 20;
  localparam int BATT_STEP    = 400;
  localparam int PID_LOW_BATT = 550;
  localparam int TURN_LIMIT   = 100;
  localparam int DIV3_MUL     = 171;
  localparam int DIV3_SHIFT   = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ONOFF = 2'd0;
  localparam logic [OP_W-1:0] OP_PID   = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // Tone codes
  localparam logic [TONE_W-1:0] TONE_NONE = 2'd0;
  localparam logic [TONE_W-1:0] TONE_LOW  = 2'd1;
  localparam logic [TONE_W-1:0] TONE_HIGH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MAGNITUDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_DT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_OVER_DT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_REF_INIT  = 3'd6;

  // Reset values
  localparam logic [SENSOR_BITS-1:0]  RST_GRAY_LEVEL     = SENSOR_BITS'(500);
  localparam logic [SPEED_W-1:0]      RST_BASE_SPEED     = 8'd30;
  localparam logic [TURN_MAG_W-1:0]   RST_TURN_MAGNITUDE = 7'd100;
  localparam logic [GAIN_W-1:0]       RST_GAIN_P         = 24'd114688;
  localparam logic [GAIN_W-1:0]       RST_GAIN_I_DT      = 24'd68;
  localparam logic [GAIN_W-1:0]       RST_GAIN_D_OVER_DT = 24'd1638400;
  localparam logic [BATT_W-1:0]       RST_BATT_REF_INIT  = 14'd9000;

  typedef struct packed {
    logic [SENSOR_BITS-1:0]   gray_level;
    logic signed [SPEED_W-1:0] base_speed;
    logic [TURN_MAG_W-1:0]    turn_magnitude;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i_dt;
    logic [GAIN_W-1:0]        gain_d_over_dt;
    logic [BATT_W-1:0]        battery_ref_init;
  } cfg_t;

  typedef struct packed {
    logic signed [FWD_W-1:0]  fwd;
    logic signed [TURN_W-1:0] turn;
    logic [TONE_W-1:0]        tone;
  } res_t;

  typedef struct packed {
    logic                     pid;
    logic signed [E_W-1:0]    err;
    logic signed [SUM_W-1:0]  err_sum;
    logic signed [DE_W-1:0]   err_delta;
    res_t                     res;
  } s1_t;

  // Signed divide by three, truncated toward zero, as multiply by reciprocal
  function automatic logic signed [SPEED_W-1:0] div3_trunc(input logic signed [SPEED_W-1:0] v);
    logic [SPEED_W:0]           mag;
    logic [SPEED_W+SPEED_W:0]   prod;
    logic [SPEED_W-1:0]         quo;
    mag  = v[SPEED_W-1] ? -{v[SPEED_W-1], v} : {1'b0, v};
    prod = (SPEED_W+SPEED_W+1)'(mag) * (SPEED_W+SPEED_W+1)'(DIV3_MUL);
    quo  = SPEED_W'(prod >> DIV3_SHIFT);
    return v[SPEED_W-1] ? -quo : quo;
  endfunction

endpackage

// ----- rtl/ltdc_cfg_regs.sv -----
// Configuration register file of the line trace drive controller.
// Depends on ltdc_pkg.
module ltdc_cfg_regs
  import ltdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic                  ref_load
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gray_level       <= RST_GRAY_LEVEL;
      cfg.base_speed       <= RST_BASE_SPEED;
      cfg.turn_magnitude   <= RST_TURN_MAGNITUDE;
      cfg.gain_p           <= RST_GAIN_P;
      cfg.gain_i_dt        <= RST_GAIN_I_DT;
      cfg.gain_d_over_dt   <= RST_GAIN_D_OVER_DT;
      cfg.battery_ref_init <= RST_BATT_REF_INIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRAY_LEVEL:     cfg.gray_level       <= cfg_data[SENSOR_BITS-1:0];
        REG_BASE_SPEED:     cfg.base_speed       <= cfg_data[SPEED_W-1:0];
        REG_TURN_MAGNITUDE: cfg.turn_magnitude   <= cfg_data[TURN_MAG_W-1:0];
        REG_GAIN_P:         cfg.gain_p           <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I_DT:      cfg.gain_i_dt        <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D_OVER_DT: cfg.gain_d_over_dt   <= cfg_data[GAIN_W-1:0];
        REG_BATT_REF_INIT:  cfg.battery_ref_init <= cfg_data[BATT_W-1:0];
        default: ;
      endcase
    end
  end

  // The live reference follows every write of its initial value
  assign ref_load = cfg_wr_en && (cfg_index == REG_BATT_REF_INIT);

endmodule

// ----- rtl/ltdc_front.sv -----
// Front stage: mode decode, on/off result, PID error terms and the controller state.
// Depends on ltdc_pkg.
module ltdc_front
  import ltdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   adv,
  input  logic [OP_W-1:0]        op,
  input  logic [SENSOR_BITS-1:0] light,
  input  logic [BATT_W-1:0]      battery_mv,
  input  cfg_t                   cfg,
  input  logic                   ref_load,
  input  logic [BATT_W-1:0]      ref_value,
  output s1_t                    s1
);

  logic [BATT_W-1:0]       battery_ref;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [E_W-1:0]   last_error;

  logic signed [E_W-1:0]   err;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] error_sum_next;
  logic signed [DE_W-1:0]  err_delta;
  logic [BATT_X_W-1:0]     batt_x;
  logic [BATT_X_W-1:0]     ref_x;
  logic                    batt_low;
  logic                    batt_high;
  logic                    batt_low_pid;
  logic                    light_below;
  logic signed [FWD_W-1:0] base_x;
  logic signed [TURN_W-1:0] turn_mag;
  s1_t                     s1_next;

  always_comb begin
    err       = $signed({1'b0, cfg.gray_level}) - $signed({1'b0, light});
    sum_wide  = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    // saturate to the signed 32-bit range
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      error_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      error_sum_next = sum_wide[SUM_W-1:0];
    end
    err_delta = DE_W'(err) - DE_W'(last_error);

    batt_x       = {1'b0, battery_mv};
    ref_x        = {1'b0, battery_ref};
    batt_low     = (batt_x + BATT_X_W'(BATT_STEP)) <= ref_x;
    batt_high    = batt_x >= (ref_x + BATT_X_W'(BATT_STEP));
    batt_low_pid = (batt_x + BATT_X_W'(PID_LOW_BATT)) <= ref_x;
    light_below  = ({1'b0, light} + LIGHT_X_W'(ONOFF_MARGIN)) < {1'b0, cfg.gray_level};

    base_x   = FWD_W'(cfg.base_speed);
    turn_mag = $signed({1'b0, cfg.turn_magnitude});

    s1_next.pid       = 1'b0;
    s1_next.err       = err;
    s1_next.err_sum   = error_sum_next;
    s1_next.err_delta = err_delta;
    s1_next.res.fwd   = '0;
    s1_next.res.turn  = '0;
    s1_next.res.tone  = TONE_NONE;

    unique case (op)
      OP_ONOFF: begin
        if (batt_low) begin
          s1_next.res.fwd  = (base_x <<< 1) + base_x;
          s1_next.res.tone = TONE_LOW;
        end else if (batt_high) begin
          s1_next.res.fwd  = FWD_W'(div3_trunc(cfg.base_speed));
          s1_next.res.tone = TONE_HIGH;
        end else begin
          s1_next.res.fwd  = base_x;
        end
        s1_next.res.turn = light_below ? -turn_mag : turn_mag;
      end
      OP_PID: begin
        s1_next.pid      = 1'b1;
        s1_next.res.fwd  = base_x;
        s1_next.res.tone = batt_low_pid ? TONE_LOW : TONE_NONE;
      end
      default: ;
    endcase
  end

  // Controller state: advance only on a PID transfer; a reference load takes priority
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_ref <= RST_BATT_REF_INIT;
      error_sum   <= '0;
      last_error  <= '0;
    end else if (ref_load) begin
      battery_ref <= ref_value;
    end else if (take && (op == OP_PID)) begin
      battery_ref <= battery_mv;
      error_sum   <= error_sum_next;
      last_error  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
    end
  end

endmodule

// ----- rtl/ltdc_pid_math.sv -----
// PID arithmetic: product stage, sum stage and the scale, negate and clamp of the turn.
// Depends on ltdc_pkg.
module ltdc_pid_math
  import ltdc_pkg::*;
(
  input  logic clk,
  input  logic adv2,
  input  logic adv3,
  input  cfg_t cfg,
  input  s1_t  s1,
  output res_t res
);

  logic signed [PP_W-1:0]  pp;
  logic signed [PI_W-1:0]  pi;
  logic signed [PD_W-1:0]  pd;
  logic                    pid2;
  res_t                    res2;

  logic signed [ACC_W-1:0] acc;
  logic                    pid3;
  res_t                    res3;

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] quo;
  logic signed [ACC_W-1:0] neg;
  logic                    round_up;
  logic signed [TURN_W-1:0] turn_clamped;

  // Products
  always_ff @(posedge clk) begin
    if (adv2) begin
      pp   <= $signed({1'b0, cfg.gain_p}) * s1.err;
      pi   <= $signed({1'b0, cfg.gain_i_dt}) * s1.err_sum;
      pd   <= $signed({1'b0, cfg.gain_d_over_dt}) * s1.err_delta;
      pid2 <= s1.pid;
      res2 <= s1.res;
    end
  end

  // Sum
  always_ff @(posedge clk) begin
    if (adv3) begin
      acc  <= ACC_W'(pp) + ACC_W'(pi) + ACC_W'(pd);
      pid3 <= pid2;
      res3 <= res2;
    end
  end

  // Truncate toward zero, negate, clamp
  always_comb begin
    acc_q    = acc >>> FRAC_W;
    round_up = acc[ACC_W-1] && (acc[FRAC_W-1:0] != '0);
    quo      = acc_q + $signed({{(ACC_W-1){1'b0}}, round_up});
    neg      = -quo;
    if (neg > ACC_W'(TURN_LIMIT)) begin
      turn_clamped = TURN_W'(TURN_LIMIT);
    end else if (neg < -ACC_W'(TURN_LIMIT)) begin
      turn_clamped = -TURN_W'(TURN_LIMIT);
    end else begin
      turn_clamped = neg[TURN_W-1:0];
    end
    res      = res3;
    if (pid3) begin
      res.turn = turn_clamped;
    end
  end

endmodule

// ----- rtl/line_trace_drive_controller.sv -----
// Line trace drive controller top level: four-stage pipeline from input transfer to result.
// A result passes the front, product and sum registers on its way to the output register.
// Throughput: one item per cycle unless the consumer stalls; the controller state advances
// on each PID transfer and items carry their error terms, so PID items need no gap.
// Reset (rst, synchronous, active high) empties the pipeline, returns the config registers
// to their defaults, clears the integral and previous error; the battery ref takes 9000 mV.
module line_trace_drive_controller
  import ltdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic [SENSOR_BITS-1:0]  light,
  input  logic [BATT_W-1:0]       battery_mv,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [FWD_W-1:0] forward_cmd,
  output logic signed [TURN_W-1:0] turn_cmd,
  output logic [TONE_W-1:0]       tone
);

  cfg_t cfg;
  logic ref_load;
  s1_t  s1;
  res_t res;

  // Stage valids: front, products, sum
  logic v1;
  logic v2;
  logic v3;

  // Advance enables: each stage moves when it is empty or its successor moves.
  // The result register holds while the consumer stalls; earlier stages keep
  // filling any bubbles behind it.
  logic adv_out;
  logic adv3;
  logic adv2;
  logic adv1;
  logic take;

  assign adv_out  = !out_valid || out_ready;
  assign adv3     = !v3 || adv_out;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign take     = in_valid && in_ready;

  ltdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .ref_load  (ref_load)
  );

  // Front: decode the mode, build the on/off result, advance PID state on transfer.
  // The live reference loads straight from the write data of its initial value.
  ltdc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .adv        (adv1),
    .op         (op),
    .light      (light),
    .battery_mv (battery_mv),
    .cfg        (cfg),
    .ref_load   (ref_load),
    .ref_value  (cfg_data[BATT_W-1:0]),
    .s1         (s1)
  );

  // PID products and sum, then scale and clamp into the turn command
  ltdc_pid_math u_pid (
    .clk  (clk),
    .adv2 (adv2),
    .adv3 (adv3),
    .cfg  (cfg),
    .s1   (s1),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv_out) begin
        out_valid <= v3;
      end
    end
  end

  // Result register: load only when it is empty or its result is being taken
  always_ff @(posedge clk) begin
    if (adv_out) begin
      forward_cmd <= res.fwd;
      turn_cmd    <= res.turn;
      tone        <= res.tone;
    end
  end

  // A full, stalled pipeline must refuse new input
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  // An item in the sum stage is never dropped when the result register frees up
  assert property (@(posedge clk) disable iff (rst)
    (v3 && adv_out) |=> out_valid)
    else $error("item lost between sum stage and result register");

  // The tone code never takes the unused value
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tone == TONE_NONE || tone == TONE_LOW || tone == TONE_HIGH))
    else $error("invalid tone code on a result");

  // Reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- dv/line_trace_drive_controller_tb.sv -----
// Testbench for line_trace_drive_controller: random and directed samples through the valid/ready
// channels, each result checked against an in-bench prediction of the drive commands.
// Depends on rtl/ltdc_pkg.sv and rtl/line_trace_drive_controller.sv.
module line_trace_drive_controller_tb;
  import ltdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;        // pipeline is 4 deep; leave some slack
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int NUM_PHASES     = 8;
  localparam int HALF_ITEMS     = 38;       // two halves per register setting
  localparam int SPEED_FACTOR   = 3;
  localparam int LIGHT_MAX      = (1 << SENSOR_BITS) - 1;
  localparam int BATT_MAX       = (1 << BATT_W) - 1;
  localparam int GAIN_MAX       = (1 << GAIN_W) - 1;
  localparam longint Q16_ONE    = longint'(1) << FRAC_W;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;

  // codes the package leaves unnamed
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [OP_W-1:0]        op;
    logic [SENSOR_BITS-1:0] light;
    logic [BATT_W-1:0]      batt;
  } sample_t;

  // DUT connections; every input starts at a known value
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           op = OP_STOP;
  logic [SENSOR_BITS-1:0]    light = '0;
  logic [BATT_W-1:0]         battery_mv = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [FWD_W-1:0]   forward_cmd;
  logic signed [TURN_W-1:0]  turn_cmd;
  logic [TONE_W-1:0]         tone;

  // register shadows, starting at the reset values
  int     gray_lvl   = int'(RST_GRAY_LEVEL);
  int     speed_base = int'($signed(RST_BASE_SPEED));
  int     turn_mag   = int'(RST_TURN_MAGNITUDE);
  longint kp         = longint'(RST_GAIN_P);
  longint ki_dt      = longint'(RST_GAIN_I_DT);
  longint kd_dt      = longint'(RST_GAIN_D_OVER_DT);

  // controller state as the predictor sees it
  int batt_ref_mv = int'(RST_BATT_REF_INIT);
  int err_sum     = 0;
  int prev_err    = 0;

  // battery reference as the generator expects it once all queued samples are in
  int plan_batt_ref = int'(RST_BATT_REF_INIT);

  sample_t samples_q[$];
  res_t    expected_cmds[$];
  sample_t drv_item;
  res_t    drv_cmds;
  res_t    mon_want;

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int src_idle       = 0;
  int sink_idle      = 0;

  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_onoff    = 0;
  int n_pid      = 0;
  int n_halt     = 0;
  int mismatches = 0;

  line_trace_drive_controller dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .light       (light),
    .battery_mv  (battery_mv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .forward_cmd (forward_cmd),
    .turn_cmd    (turn_cmd),
    .tone        (tone)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Work out the commands for one accepted sample and advance the controller state.
  task automatic predict_cmds(input sample_t s, output res_t r);
    int batt, lgt, fwd, trn, e;
    logic [TONE_W-1:0] tn;
    longint sum, acc, t;
    batt = int'(s.batt);
    lgt  = int'(s.light);
    fwd  = 0;
    trn  = 0;
    tn   = TONE_NONE;
    case (s.op)
      OP_ONOFF: begin
        // low battery boosts the speed, high battery cuts it
        if (batt <= batt_ref_mv - BATT_STEP) begin
          fwd = speed_base * SPEED_FACTOR;
          tn  = TONE_LOW;
        end else if (batt >= batt_ref_mv + BATT_STEP) begin
          fwd = speed_base / SPEED_FACTOR;
          tn  = TONE_HIGH;
        end else begin
          fwd = speed_base;
        end
        trn = (lgt < gray_lvl - ONOFF_MARGIN) ? -turn_mag : turn_mag;
      end
      OP_PID: begin
        e   = gray_lvl - lgt;
        sum = longint'(err_sum) + e;
        if (sum > SUM_MAX) sum = SUM_MAX;
        if (sum < SUM_MIN) sum = SUM_MIN;
        err_sum = int'(sum);
        acc = kp * e + ki_dt * err_sum + kd_dt * (e - prev_err);
        // negate, drop the fraction toward zero, then clamp
        t = -(acc / Q16_ONE);
        if (t > TURN_LIMIT) t = TURN_LIMIT;
        if (t < -TURN_LIMIT) t = -TURN_LIMIT;
        trn = int'(t);
        fwd = speed_base;
        tn  = (batt <= batt_ref_mv - PID_LOW_BATT) ? TONE_LOW : TONE_NONE;
        prev_err    = e;
        batt_ref_mv = batt;
      end
      default: ;  // stop and the unused code hold everything at zero
    endcase
    r.fwd  = FWD_W'(fwd);
    r.turn = TURN_W'(trn);
    r.tone = tn;
  endtask

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 40));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 45;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    if ($urandom_range(0, 1) == 0) return CFG_DATA_W'($urandom_range(0, 1 << 18));
    return CFG_DATA_W'($urandom_range(0, GAIN_MAX));
  endfunction

  function automatic void add_sample(input logic [OP_W-1:0] code, input int lgt, input int batt);
    sample_t s;
    s.op    = code;
    s.light = SENSOR_BITS'(lgt);
    s.batt  = BATT_W'(batt);
    samples_q.push_back(s);
    n_queued++;
    if (code == OP_PID) plan_batt_ref = batt;
  endfunction

  // Random sample biased toward the light threshold and the battery steps.
  function automatic void add_random_sample();
    int pick, lgt, batt;
    logic [OP_W-1:0] code;
    pick = int'($urandom_range(0, 99));
    if (pick < 40)      code = OP_ONOFF;
    else if (pick < 85) code = OP_PID;
    else if (pick < 95) code = OP_STOP;
    else                code = OP_UNUSED;

    pick = int'($urandom_range(0, 99));
    if (pick < 20)      lgt = gray_lvl - ONOFF_MARGIN + int'($urandom_range(0, 6)) - 3;
    else if (pick < 40) lgt = gray_lvl + int'($urandom_range(0, 60)) - 30;
    else if (pick < 50) lgt = ($urandom_range(0, 1) == 0) ? 0 : LIGHT_MAX;
    else                lgt = int'($urandom_range(0, LIGHT_MAX));
    lgt = clip(lgt, 0, LIGHT_MAX);

    pick = int'($urandom_range(0, 99));
    if (pick < 45) begin
      case ($urandom_range(0, 2))
        0:       batt = plan_batt_ref - BATT_STEP;
        1:       batt = plan_batt_ref + BATT_STEP;
        default: batt = plan_batt_ref - PID_LOW_BATT;
      endcase
      batt = batt + int'($urandom_range(0, 2)) - 1;
    end else if (pick < 55) begin
      batt = ($urandom_range(0, 1) == 0) ? 0 : BATT_MAX;
    end else begin
      batt = int'($urandom_range(0, BATT_MAX));
    end
    add_sample(code, lgt, clip(batt, 0, BATT_MAX));
  endfunction

  // One register write; the port only moves while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_GRAY_LEVEL:     gray_lvl   = int'(val[SENSOR_BITS-1:0]);
      REG_BASE_SPEED:     speed_base = int'($signed(val[SPEED_W-1:0]));
      REG_TURN_MAGNITUDE: turn_mag   = int'(val[TURN_MAG_W-1:0]);
      REG_GAIN_P:         kp         = longint'(val[GAIN_W-1:0]);
      REG_GAIN_I_DT:      ki_dt      = longint'(val[GAIN_W-1:0]);
      REG_GAIN_D_OVER_DT: kd_dt      = longint'(val[GAIN_W-1:0]);
      REG_BATT_REF_INIT: begin
        // the initial reference also reloads the live reference
        batt_ref_mv   = int'(val[BATT_W-1:0]);
        plan_batt_ref = batt_ref_mv;
      end
      default: ;  // unmapped index: no effect
    endcase
  endtask

  task automatic program_phase(input int ph);
    case (ph)
      0: begin
        // bottom of every range but the turn magnitude, which goes to its top
        write_reg(REG_GRAY_LEVEL, '0);
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(SPEED_W'(-128)));
        write_reg(REG_TURN_MAGNITUDE, CFG_DATA_W'((1 << TURN_MAG_W) - 1));
        write_reg(REG_GAIN_P, '0);
        write_reg(REG_GAIN_I_DT, '0);
        write_reg(REG_GAIN_D_OVER_DT, '0);
        write_reg(REG_BATT_REF_INIT, '0);
      end
      1: begin
        // top of every range but the turn magnitude, which goes to zero
        write_reg(REG_GRAY_LEVEL, CFG_DATA_W'(LIGHT_MAX));
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(127));
        write_reg(REG_TURN_MAGNITUDE, '0);
        write_reg(REG_GAIN_P, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_GAIN_I_DT, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_GAIN_D_OVER_DT, CFG_DATA_W'(GAIN_MAX));
        write_reg(REG_BATT_REF_INIT, CFG_DATA_W'(BATT_MAX));
      end
      2: begin
        // threshold right at the margin, so gray - 20 lands on zero
        write_reg(REG_GRAY_LEVEL, CFG_DATA_W'(ONOFF_MARGIN));
        write_reg(REG_BASE_SPEED, CFG_DATA_W'(SPEED_W'(-100)));
        write_reg(REG_TURN_MAGNITUDE, CFG_DATA_W'(TURN_LIMIT));
        write_reg(REG_GAIN_P, CFG_DATA_W'(RST_GAIN_P));
        write_reg(REG_GAIN_I_DT, CFG_DATA_W'(RST_GAIN_I_DT));
        write_reg(REG_GAIN_D_OVER_DT, CFG_DATA_W'(RST_GAIN_D_OVER_DT));
        write_reg(REG_BATT_REF_INIT, CFG_DATA_W'($urandom_range(0, BATT_MAX)));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, GAIN_MAX)));
      end
      default: begin
        write_reg(REG_GRAY_LEVEL, CFG_DATA_W'($urandom_range(0, LIGHT_MAX)));
        write_reg(REG_BASE_SPEED, CFG_DATA_W'($urandom_range(0, (1 << SPEED_W) - 1)));
        write_reg(REG_TURN_MAGNITUDE, CFG_DATA_W'($urandom_range(0, (1 << TURN_MAG_W) - 1)));
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I_DT, pick_gain());
        write_reg(REG_GAIN_D_OVER_DT, pick_gain());
        write_reg(REG_BATT_REF_INIT, CFG_DATA_W'($urandom_range(0, BATT_MAX)));
      end
    endcase
  endtask

  // Hold until every queued sample has been transferred and its result checked.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: predict on each transfer, then present the next sample or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_idle <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_cmds(drv_item, drv_cmds);
        expected_cmds.push_back(drv_cmds);
        n_accepted++;
        case (drv_item.op)
          OP_ONOFF: n_onoff++;
          OP_PID:   n_pid++;
          default:  n_halt++;
        endcase
      end
      // the slot is free once nothing is pending on the channel
      if (!in_valid || in_ready) begin
        if (src_idle > 0) begin
          in_valid <= 1'b0;
          src_idle <= src_idle - 1;
        end else if (samples_q.size() > 0) begin
          drv_item   = samples_q.pop_front();
          in_valid   <= 1'b1;
          op         <= drv_item.op;
          light      <= drv_item.light;
          battery_mv <= drv_item.batt;
          if (int'($urandom_range(0, 99)) < src_gap_pct) src_idle <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Monitor: compare each result transfer with the oldest prediction; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_idle <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_cmds.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, fwd %0d turn %0d tone %0d",
                   $time, forward_cmd, turn_cmd, tone);
        end else begin
          mon_want = expected_cmds.pop_front();
          check_field("forward_cmd", int'(mon_want.fwd), int'(forward_cmd));
          check_field("turn_cmd", int'(mon_want.turn), int'(turn_cmd));
          check_field("tone", int'(mon_want.tone), int'(tone));
        end
      end
      if (sink_idle > 0) begin
        out_ready <= 1'b0;
        sink_idle <= sink_idle - 1;
      end else if (int'($urandom_range(0, 99)) < sink_stall_pct) begin
        out_ready <= 1'b0;
        sink_idle <= pick_gap() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed samples at the reset register values.
    src_gap_pct    = 15;
    sink_stall_pct = 15;
    // on/off: both sides of the light threshold and of each battery step
    add_sample(OP_ONOFF, gray_lvl - ONOFF_MARGIN - 1, plan_batt_ref);
    add_sample(OP_ONOFF, gray_lvl - ONOFF_MARGIN, plan_batt_ref - BATT_STEP);
    add_sample(OP_ONOFF, gray_lvl - ONOFF_MARGIN + 1, plan_batt_ref - BATT_STEP + 1);
    add_sample(OP_ONOFF, 0, plan_batt_ref + BATT_STEP - 1);
    add_sample(OP_ONOFF, LIGHT_MAX, plan_batt_ref + BATT_STEP);
    add_sample(OP_ONOFF, 0, 0);
    add_sample(OP_ONOFF, LIGHT_MAX, BATT_MAX);
    // stop and the unused code
    add_sample(OP_STOP, LIGHT_MAX, BATT_MAX);
    add_sample(OP_UNUSED, 0, 0);
    add_sample(OP_UNUSED, LIGHT_MAX, BATT_MAX);
    // PID: low-battery tone edge, full error swings, zero error
    add_sample(OP_PID, LIGHT_MAX, plan_batt_ref - PID_LOW_BATT);
    add_sample(OP_PID, 0, plan_batt_ref - PID_LOW_BATT + 1);
    add_sample(OP_PID, gray_lvl, BATT_MAX);
    add_sample(OP_PID, 0, 0);
    add_sample(OP_PID, LIGHT_MAX, 0);
    // on/off against a reference of zero: the low step falls below zero
    add_sample(OP_ONOFF, gray_lvl, 0);
    add_sample(OP_ONOFF, gray_lvl, BATT_STEP);
    // stop between PID samples must leave the integral and last error alone
    add_sample(OP_STOP, 0, 12345);
    add_sample(OP_PID, gray_lvl + 100, 100);
    add_sample(OP_PID, gray_lvl + 100, 100);
    wait_drained();

    // Random samples under a series of register settings.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_phase(ph);
      for (int half = 0; half < 2; half++) begin
        src_gap_pct    = pick_pct();
        sink_stall_pct = pick_pct();
        if (ph == 2 && half == 0) begin
          // one stretch at full rate in both directions
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        repeat (HALF_ITEMS) add_random_sample();
        // the sender pauses here until every result is back
        wait_drained();
      end
    end

    $display("checked %0d results from %0d samples: %0d on/off, %0d PID, %0d stop or unused",
             n_results, n_accepted, n_onoff, n_pid, n_halt);
    $display("register settings: reset values plus %0d programmed, range ends included",
             NUM_PHASES);
    if (mismatches == 0) begin
      $display("line_trace_drive_controller test passed");
    end else begin
      $display("line_trace_drive_controller test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout: %0d samples queued, %0d transferred, %0d results",
             n_queued, n_accepted, n_results);
    $display("line_trace_drive_controller test failed");
    $finish;
  end

endmodule
